>>> sv/ums_pkg.sv
// Shared types and constants for the unsharp-mask sharpener.
// No dependencies; every other file except ums_ram refers to it by scoped names.
package ums_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned CFG_W_BITS = 11;
  localparam int unsigned CFG_H_BITS = 13;
  localparam int unsigned CFG_S_BITS = 12;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH      = 2'd0,
    REG_IMAGE_HEIGHT     = 2'd1,
    REG_SHARPEN_STRENGTH = 2'd2
  } ums_reg_e;

  // red [7:0], green [15:8], blue [23:16], alpha [31:24]
  typedef logic [31:0] ums_pix_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } ums_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       end_of_line;
    logic       end_of_frame;
  } ums_out_t;

  // Position flags of an accepted item, from the sequencer to the window.
  typedef struct packed {
    logic top_clamp;  // column's centre row is the first line
    logic bot_clamp;  // column's centre row is the last line
    logic col_first;  // item at column 0: result is the last pixel of a line
    logic x_first;    // result pixel sits in column 0
    logic emit;       // item releases a result
    logic eof;        // item releases the last result of the frame
  } ums_tag_t;

  typedef struct packed {
    ums_pix_t [8:0] tap;
    logic           eol;
    logic           eof;
  } ums_win_t;

endpackage

>>> sv/ums_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Read during write to the same address returns the old contents.
module ums_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/ums_ctrl.sv
// Frame sequencer: latches the frame size, tracks column and row of the next item.
// Depends on ums_pkg.
module ums_ctrl #(
  parameter int unsigned MAX_WIDTH  = ums_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = ums_pkg::MAX_HEIGHT_DEF,
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned CW = $clog2(MAX_WIDTH),
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 2)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic [ums_pkg::CFG_W_BITS-1:0]  cfg_width_i,
  input  logic [ums_pkg::CFG_H_BITS-1:0]  cfg_height_i,
  output logic [CW-1:0]                   col_o,
  output ums_pkg::ums_tag_t               tag_o
);

  logic          open_q, open_d;
  logic [WW-1:0] fw_q, fw_d, cur_w;
  logic [HW-1:0] fh_q, fh_d, cur_h;
  logic [CW-1:0] col_q, col_d, cur_col;
  logic [RW-1:0] row_q, row_d, cur_row;
  ums_pkg::ums_tag_t tag;

  // a closed frame opens on the next item with the size registers clamped
  always_comb begin
    if (!open_q) begin
      if (cfg_width_i == '0) begin
        cur_w = WW'(1);
      end else if (32'(cfg_width_i) > MAX_WIDTH) begin
        cur_w = WW'(MAX_WIDTH);
      end else begin
        cur_w = WW'(cfg_width_i);
      end
      if (cfg_height_i == '0) begin
        cur_h = HW'(1);
      end else if (32'(cfg_height_i) > MAX_HEIGHT) begin
        cur_h = HW'(MAX_HEIGHT);
      end else begin
        cur_h = HW'(cfg_height_i);
      end
      cur_col = '0;
      cur_row = '0;
    end else begin
      cur_w   = fw_q;
      cur_h   = fh_q;
      cur_col = col_q;
      cur_row = row_q;
    end
  end

  // result centre sits one line and one pixel behind the incoming item
  always_comb begin
    tag.col_first = (cur_col == '0);
    tag.x_first   = (cur_col == CW'(1)) || (tag.col_first && cur_w == WW'(1));
    tag.top_clamp = (cur_row == RW'(1));
    tag.bot_clamp = (32'(cur_row) == 32'(cur_h));
    tag.emit      = (32'(cur_row) >= 32'd2) || ((cur_row == RW'(1)) && !tag.col_first);
    tag.eof       = tag.col_first && (32'(cur_row) == 32'(cur_h) + 32'd1);
  end

  always_comb begin
    open_d = open_q;
    fw_d   = fw_q;
    fh_d   = fh_q;
    col_d  = col_q;
    row_d  = row_q;
    if (accept_i) begin
      open_d = !tag.eof;
      fw_d   = cur_w;
      fh_d   = cur_h;
      if (32'(cur_col) + 32'd1 >= 32'(cur_w)) begin
        col_d = '0;
        row_d = cur_row + RW'(1);
      end else begin
        col_d = cur_col + CW'(1);
        row_d = cur_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      fw_q   <= '0;
      fh_q   <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      open_q <= open_d;
      fw_q   <= fw_d;
      fh_q   <= fh_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

  assign col_o = cur_col;
  assign tag_o = tag;

endmodule

>>> sv/ums_window.sv
// Line store read-modify-write and 3x3 window assembly with edge replication.
// Depends on ums_pkg and ums_ram.
module ums_window #(
  parameter int unsigned MAX_WIDTH = ums_pkg::MAX_WIDTH_DEF,
  localparam int unsigned CW = $clog2(MAX_WIDTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CW-1:0]      col_i,
  input  ums_pkg::ums_tag_t  tag_i,
  input  ums_pkg::ums_pix_t  pix_i,
  output logic               win_valid_o,
  input  logic               win_ready_i,
  output ums_pkg::ums_win_t  win_o
);

  localparam int unsigned PW   = $bits(ums_pkg::ums_pix_t);
  localparam int unsigned LB_W = 2 * PW;

  typedef struct packed {
    ums_pkg::ums_pix_t top;
    ums_pkg::ums_pix_t mid;
    ums_pkg::ums_pix_t bot;
  } col_t;

  logic              s1_v_q, s2_v_q, fwd_q, fwd_d;
  ums_pkg::ums_tag_t s1_tag_q;
  logic [CW-1:0]     s1_col_q;
  ums_pkg::ums_pix_t s1_pix_q;
  logic [LB_W-1:0]   rd_data, fwd_data_q, entry, wr_data;
  logic              accept, s1_adv, s2_ready;
  col_t              col_now, col_a_q, col_b_q, left, right;
  ums_pkg::ums_win_t win_d, win_q;

  assign s2_ready   = !s2_v_q || win_ready_i;
  assign s1_adv     = s1_v_q && s2_ready;
  assign in_ready_o = !s1_v_q || s2_ready;
  assign accept     = in_valid_i && in_ready_o;

  // entry = {line r-2, line r-1} at this column
  ums_ram #(
    .WIDTH (LB_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (wr_data),
    .re_i    (accept),
    .raddr_i (col_i),
    .rdata_o (rd_data)
  );

  // one-pixel lines hit the same entry on consecutive items
  assign fwd_d = s1_adv && (col_i == s1_col_q);

  always_comb begin
    entry       = fwd_q ? fwd_data_q : rd_data;
    wr_data     = {entry[PW-1:0], s1_pix_q};
    col_now.mid = entry[PW-1:0];
    col_now.top = s1_tag_q.top_clamp ? entry[PW-1:0] : entry[LB_W-1:PW];
    col_now.bot = s1_tag_q.bot_clamp ? entry[PW-1:0] : s1_pix_q;
    left        = s1_tag_q.x_first ? col_a_q : col_b_q;
    right       = s1_tag_q.col_first ? col_a_q : col_now;
    win_d.tap[0] = left.top;
    win_d.tap[1] = col_a_q.top;
    win_d.tap[2] = right.top;
    win_d.tap[3] = left.mid;
    win_d.tap[4] = col_a_q.mid;
    win_d.tap[5] = right.mid;
    win_d.tap[6] = left.bot;
    win_d.tap[7] = col_a_q.bot;
    win_d.tap[8] = right.bot;
    win_d.eol    = s1_tag_q.col_first;
    win_d.eof    = s1_tag_q.eof;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      fwd_q  <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_q <= 1'b1;
        fwd_q  <= fwd_d;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_q <= s1_tag_q.emit;
      end else if (win_ready_i) begin
        s2_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_tag_q   <= tag_i;
      s1_col_q   <= col_i;
      s1_pix_q   <= pix_i;
      fwd_data_q <= wr_data;
    end
    if (s1_adv) begin
      col_a_q <= col_now;
      col_b_q <= col_a_q;
      win_q   <= win_d;
    end
  end

  assign win_valid_o = s2_v_q;
  assign win_o       = win_q;

endmodule

>>> sv/ums_sharpen.sv
// Arithmetic pipeline: 3x3 sums, box mean, Q4.8 gain on the difference, saturation.
// Depends on ums_pkg.
module ums_sharpen (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  win_valid_i,
  output logic                                  win_ready_o,
  input  ums_pkg::ums_win_t                     win_i,
  input  logic signed [ums_pkg::CFG_S_BITS-1:0] strength_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output ums_pkg::ums_out_t                     out_o
);

  localparam int unsigned NUM_CH = 3;
  localparam int unsigned TAPS   = 9;
  localparam int unsigned CENTRE = 4;
  localparam int unsigned SUM_W  = 12;
  localparam int unsigned PROD_W = 25;
  localparam int unsigned MUL_W  = 21;
  localparam int unsigned T_W    = 22;
  // floor(x/9) == (x*7282) >> 16 for x up to 9*255
  localparam logic [12:0] RECIP9 = 13'd7282;

  logic a_v_q, b_v_q, c_v_q, out_v_q;
  logic a_ready, b_ready, c_ready, d_ready;

  logic [NUM_CH-1:0][SUM_W-1:0]  sum_d, a_sum_q;
  logic [NUM_CH-1:0][7:0]        p_d, a_p_q, b_p_q, b_blur_d, b_blur_q;
  logic [NUM_CH-1:0][PROD_W-1:0] prod;
  logic [NUM_CH-1:0][7:0]        sat;
  logic signed [8:0]             diff  [NUM_CH];
  logic signed [MUL_W-1:0]       mul   [NUM_CH];
  logic signed [T_W-1:0]         t_d   [NUM_CH];
  logic signed [T_W-1:0]         c_t_q [NUM_CH];
  logic [7:0]        a_alpha_q, b_alpha_q, c_alpha_q;
  logic              a_eol_q, b_eol_q, c_eol_q, a_eof_q, b_eof_q, c_eof_q;
  ums_pkg::ums_out_t out_d, out_q;

  assign d_ready     = !out_v_q || out_ready_i;
  assign c_ready     = !c_v_q || d_ready;
  assign b_ready     = !b_v_q || c_ready;
  assign a_ready     = !a_v_q || b_ready;
  assign win_ready_o = a_ready;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum_d[ch] = '0;
      for (int j = 0; j < TAPS; j++) begin
        sum_d[ch] = sum_d[ch] + SUM_W'(win_i.tap[j][8*ch +: 8]);
      end
      p_d[ch] = win_i.tap[CENTRE][8*ch +: 8];
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod[ch]     = PROD_W'(a_sum_q[ch]) * PROD_W'(RECIP9);
      b_blur_d[ch] = prod[ch][23:16];
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      diff[ch] = $signed({1'b0, b_p_q[ch]}) - $signed({1'b0, b_blur_q[ch]});
      mul[ch]  = MUL_W'(strength_i) * MUL_W'(diff[ch]);
      t_d[ch]  = T_W'(mul[ch]) + $signed({6'h00, b_p_q[ch], 8'h00});
    end
  end

  // negative clips to zero, anything past 255 after the shift to 255
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (c_t_q[ch][T_W-1]) begin
        sat[ch] = 8'h00;
      end else if (c_t_q[ch][T_W-2:16] != '0) begin
        sat[ch] = 8'hff;
      end else begin
        sat[ch] = c_t_q[ch][15:8];
      end
    end
    out_d.red_out      = sat[0];
    out_d.green_out    = sat[1];
    out_d.blue_out     = sat[2];
    out_d.alpha_out    = c_alpha_q;
    out_d.end_of_line  = c_eol_q;
    out_d.end_of_frame = c_eof_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_v_q <= win_valid_i;
      end
      if (b_ready) begin
        b_v_q <= a_v_q;
      end
      if (c_ready) begin
        c_v_q <= b_v_q;
      end
      if (d_ready) begin
        out_v_q <= c_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready) begin
      a_sum_q   <= sum_d;
      a_p_q     <= p_d;
      a_alpha_q <= win_i.tap[CENTRE][31:24];
      a_eol_q   <= win_i.eol;
      a_eof_q   <= win_i.eof;
    end
    if (b_ready) begin
      b_blur_q  <= b_blur_d;
      b_p_q     <= a_p_q;
      b_alpha_q <= a_alpha_q;
      b_eol_q   <= a_eol_q;
      b_eof_q   <= a_eof_q;
    end
    if (c_ready) begin
      c_t_q     <= t_d;
      c_alpha_q <= b_alpha_q;
      c_eol_q   <= b_eol_q;
      c_eof_q   <= b_eof_q;
    end
    if (d_ready) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule

>>> sv/unsharp_mask_sharpen.sv
// Unsharp-mask sharpener, top level: register port, sequencer, window, arithmetic.
// Depends on ums_pkg, ums_ctrl, ums_window (with ums_ram) and ums_sharpen.
//
// Usage:
//   Pixels enter in raster order on the in_* valid/ready channel; sharpened
//   pixels leave on out_* with end_of_line and end_of_frame flags. After the
//   W*H pixels of a frame the source sends W+1 pad items, which flush the
//   last line and a pixel out of the window. The result for pixel k follows
//   the transfer of item k+W+1 through the window and arithmetic stages;
//   items releasing no result (the first W+1 of a frame) leave nothing behind.
//   Throughput is one item per clock unless the output stalls: the line store is
//   read on a transfer and written back as the item leaves the first window stage,
//   one entry per cycle, with a bypass when the next item has the same column (one-pixel lines).
//   Width and height are latched at the first item of a frame; strength is
//   applied as results are computed. Write the registers only while idle.
//   A stalled receiver holds the output register; the pipeline stages keep
//   filling and in_ready_o falls only once every stage is occupied.
//   Reset restores the register defaults and closes the frame. The line store
//   is not cleared: entries are always written before they are used.
module unsharp_mask_sharpen #(
  parameter int unsigned MAX_WIDTH  = ums_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = ums_pkg::MAX_HEIGHT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  ums_pkg::ums_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output ums_pkg::ums_out_t            out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ums_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  logic [ums_pkg::CFG_W_BITS-1:0]        width_q;
  logic [ums_pkg::CFG_H_BITS-1:0]        height_q;
  logic signed [ums_pkg::CFG_S_BITS-1:0] strength_q;
  ums_pkg::ums_reg_e                     reg_idx;

  logic              accept, win_valid, win_ready;
  logic [CW-1:0]     col;
  ums_pkg::ums_tag_t tag;
  ums_pkg::ums_pix_t pix;
  ums_pkg::ums_win_t win;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = ums_pkg::ums_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= ums_pkg::CFG_W_BITS'(1024);
      height_q   <= ums_pkg::CFG_H_BITS'(1);
      strength_q <= ums_pkg::CFG_S_BITS'(256);
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        ums_pkg::REG_IMAGE_WIDTH:      width_q    <= pwdata[ums_pkg::CFG_W_BITS-1:0];
        ums_pkg::REG_IMAGE_HEIGHT:     height_q   <= pwdata[ums_pkg::CFG_H_BITS-1:0];
        ums_pkg::REG_SHARPEN_STRENGTH: strength_q <= pwdata[ums_pkg::CFG_S_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ums_pkg::REG_IMAGE_WIDTH:      prdata = 32'(width_q);
      ums_pkg::REG_IMAGE_HEIGHT:     prdata = 32'(height_q);
      ums_pkg::REG_SHARPEN_STRENGTH: prdata = {20'h00000, strength_q};
      default:                       prdata = '0;
    endcase
  end

  // datapath
  assign accept = in_valid_i && in_ready_o;
  assign pix    = {in_data_i.alpha_in, in_data_i.blue_in, in_data_i.green_in,
                   in_data_i.red_in};

  ums_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .cfg_width_i  (width_q),
    .cfg_height_i (height_q),
    .col_o        (col),
    .tag_o        (tag)
  );

  ums_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .col_i       (col),
    .tag_i       (tag),
    .pix_i       (pix),
    .win_valid_o (win_valid),
    .win_ready_i (win_ready),
    .win_o       (win)
  );

  ums_sharpen u_sharpen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_valid_i (win_valid),
    .win_ready_o (win_ready),
    .win_i       (win),
    .strength_i  (strength_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_data_o)
  );

endmodule
